// ----- design/tvdsb_pkg.sv -----
// Shared types and constants for the superbee advection coefficient block.
`timescale 1ns / 1ps

package tvdsb_pkg;

   // Width of every field value, velocity and coefficient
   localparam int FIELD_W = 32;

   // Register index as decoded from the word address bit of the CSR port
   localparam logic CSR_IDX_INV_CELL_WIDTH = 1'b0;

   // Sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PREP,
      ST_DIV,
      ST_PHI,
      ST_MUL_LO,
      ST_MUL_HI,
      ST_SUM,
      ST_ROW,
      ST_SEND_ROW,
      ST_SEND_FINAL
   } tvdsb_state_type;

endpackage

// ----- design/tvd_superbee_advection_coeffs_core.sv -----
// Superbee-limited upwind advection: tridiagonal row coefficients per cell edge.
`timescale 1ns / 1ps

//  channel  | dir | handshake            | payload
//  ---------+-----+----------------------+-----------------------------------------
//  req_     | in  | tvalid/tready        | tdata: 5 x 32b fields, tuser: first, tlast: last
//  rsp_     | out | tvalid/tready        | tdata: lower, diag, upper, tlast: last_row
//  csr_     | in  | psel/penable/pready  | inv_cell_width at byte address 0
//
//  An edge's first row beat is offered once the serial ratio divider (FRAC_BITS + 2 steps,
//  one quotient bit a cycle) and the shared 32x32 multiplier (three passes) are done.
//  A new edge is taken only after the last row beat of the previous one is sent; a last
//  edge sends one more row beat.
//  req_tready is high only in idle; the block waits for rsp_tready as long as needed.
//  Synchronous active-high reset clears the sequencer, the pending row shares and
//  sets inv_cell_width to 1.0.

module tvd_superbee_advection_coeffs_core
   import tvdsb_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  logic           clock,
   input  logic           reset,

   input  logic           req_tvalid,
   output logic           req_tready,
   // [31:0] field_before, [63:32] field_here, [95:64] field_after,
   // [127:96] field_after_two, [159:128] edge_velocity
   input  logic [159:0]   req_tdata,
   // [0] first_edge
   input  logic [0:0]     req_tuser,
   input  logic           req_tlast,

   output logic           rsp_tvalid,
   input  logic           rsp_tready,
   // [31:0] lower_coeff, [63:32] diag_coeff, [95:64] upper_coeff
   output logic [95:0]    rsp_tdata,
   output logic           rsp_tlast,

   input  logic           csr_psel,
   input  logic           csr_penable,
   input  logic           csr_pwrite,
   input  logic [2:0]     csr_paddr,
   input  logic [31:0]    csr_pwdata,
   output logic [31:0]    csr_prdata,
   output logic           csr_pready
);

   // quotient / phi width, divider remainder width, scaled velocity width
   localparam int QW = FRAC_BITS + 2;
   localparam int CW = $clog2(QW);
   localparam int RW = FIELD_W + 3;
   localparam int MW = 2 * FIELD_W - FRAC_BITS;

   localparam logic [QW-1:0] PHI_HALF = {3'b001, {(FRAC_BITS - 1){1'b0}}};
   localparam logic [QW-1:0] PHI_ONE  = {2'b01, {FRAC_BITS{1'b0}}};
   localparam logic [QW-1:0] PHI_TWO  = {2'b10, {FRAC_BITS{1'b0}}};

   localparam logic [FIELD_W-1:0] SAT_MAX = {1'b0, {(FIELD_W - 1){1'b1}}};
   localparam logic [FIELD_W-1:0] SAT_MIN = {1'b1, {(FIELD_W - 1){1'b0}}};

   // saturate a nonnegative magnitude to a signed word
   function automatic logic [FIELD_W-1:0] sat_pos(input logic [MW-1:0] x);
      logic [FIELD_W-1:0] r;
      if (x > MW'(SAT_MAX)) begin
         r = SAT_MAX;
      end else begin
         r = x[FIELD_W-1:0];
      end
      return r;
   endfunction

   // saturate the negation of a nonnegative magnitude to a signed word
   function automatic logic [FIELD_W-1:0] sat_neg(input logic [MW-1:0] x);
      logic [FIELD_W-1:0] r;
      if (x > MW'(SAT_MIN)) begin
         r = SAT_MIN;
      end else begin
         r = FIELD_W'(0) - x[FIELD_W-1:0];
      end
      return r;
   endfunction

   tvdsb_state_type state_ff, state_in;

   logic [FIELD_W-1:0]        icw_ff, icw_in;
   logic [FIELD_W-1:0]        pend_lower_ff, pend_lower_in;
   logic [FIELD_W-1:0]        pend_diag_ff, pend_diag_in;

   logic signed [FIELD_W:0]   num_ff, num_in;
   logic signed [FIELD_W:0]   den_ff, den_in;
   logic signed [FIELD_W-1:0] vel_ff, vel_in;
   logic                      first_ff, first_in;
   logic                      last_ff, last_in;

   logic [RW-1:0]             rem_ff, rem_in;
   logic [RW-1:0]             dvs_ff, dvs_in;
   logic [QW-1:0]             quo_ff, quo_in;
   logic                      big_ff, big_in;
   logic [CW-1:0]             cnt_ff, cnt_in;
   logic [QW-1:0]             phi_ff, phi_in;

   logic [2*FIELD_W-1:0]      prod_ff, prod_in;
   logic [2*FIELD_W-1:0]      acc_ff, acc_in;
   logic [MW-1:0]             m_ff, m_in;
   logic [MW-1:0]             p_ff, p_in;

   logic [FIELD_W-1:0]        out_lower_ff, out_lower_in;
   logic [FIELD_W-1:0]        out_diag_ff, out_diag_in;
   logic [FIELD_W-1:0]        out_upper_ff, out_upper_in;
   logic                      out_last_ff, out_last_in;

   // stencil selection from the request beat
   logic signed [FIELD_W-1:0] f_before, f_here, f_after, f_after2, f_vel;
   logic signed [FIELD_W-1:0] st_cr, st_up, st_dn;
   logic                      use_left;

   // shared multiplier operands
   logic [FIELD_W-1:0]        mul_a, mul_b;

   // working values
   logic [FIELD_W:0]          abs_num, abs_den;
   logic [FIELD_W-1:0]        abs_vel;
   logic [RW:0]               two_rem, trial;
   logic [2*FIELD_W+1:0]      prod_sum;
   logic [MW-1:0]             m_minus_p;
   logic [FIELD_W-1:0]        s_p, s_mp, n_p, n_mp;
   logic [FIELD_W-1:0]        diag_share, upper_share, next_lower, next_diag;
   logic [FIELD_W-1:0]        row_lower, row_pdiag;
   logic signed [FIELD_W:0]   diag_sum;
   logic [FIELD_W-1:0]        diag_sat;
   logic                      den_zero, num_zero;

   logic req_fire, rsp_fire, csr_write;

   assign req_fire  = req_tvalid && req_tready;
   assign rsp_fire  = rsp_tvalid && rsp_tready;
   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // handshake and register read
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = (state_ff == ST_SEND_ROW) || (state_ff == ST_SEND_FINAL);
   assign rsp_tdata  = {out_upper_ff, out_diag_ff, out_lower_ff};
   assign rsp_tlast  = out_last_ff;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == CSR_IDX_INV_CELL_WIDTH) ? icw_ff : '0;

   // request field unpacking and upwind stencil
   assign f_before = req_tdata[31:0];
   assign f_here   = req_tdata[63:32];
   assign f_after  = req_tdata[95:64];
   assign f_after2 = req_tdata[127:96];
   assign f_vel    = req_tdata[159:128];
   assign use_left = (!f_vel[FIELD_W-1] && (f_vel != '0) && !req_tuser[0]) || req_tlast;
   assign st_cr    = use_left ? f_here  : f_after;
   assign st_up    = use_left ? f_after : f_here;
   assign st_dn    = use_left ? f_before : f_after2;

   // magnitudes of the captured ratio operands and velocity
   assign abs_num  = num_ff[FIELD_W] ? (FIELD_W + 1)'(-num_ff) : (FIELD_W + 1)'(num_ff);
   assign abs_den  = den_ff[FIELD_W] ? (FIELD_W + 1)'(-den_ff) : (FIELD_W + 1)'(den_ff);
   assign abs_vel  = vel_ff[FIELD_W-1] ? FIELD_W'(-vel_ff) : FIELD_W'(vel_ff);
   assign den_zero = (den_ff == '0);
   assign num_zero = (num_ff == '0);

   // divider step: remainder doubled against four times the denominator
   assign two_rem = {rem_ff, 1'b0};
   assign trial   = two_rem - {1'b0, dvs_ff};

   // product accumulation for p = m * phi >> (FRAC_BITS + 1)
   assign prod_sum = (2 * FIELD_W + 2)'(acc_ff) + ((2 * FIELD_W + 2)'(prod_ff) << FIELD_W);

   // saturated transport shares
   assign m_minus_p = m_ff - p_ff;
   assign s_p  = sat_pos(p_ff);
   assign s_mp = sat_pos(m_minus_p);
   assign n_p  = sat_neg(p_ff);
   assign n_mp = sat_neg(m_minus_p);

   assign diag_share  = vel_ff[FIELD_W-1] ? n_p  : s_mp;
   assign upper_share = vel_ff[FIELD_W-1] ? n_mp : s_p;
   assign next_lower  = vel_ff[FIELD_W-1] ? s_p  : n_mp;
   assign next_diag   = vel_ff[FIELD_W-1] ? s_mp : n_p;

   // a first edge starts the grid with empty pending shares
   assign row_lower = first_ff ? '0 : pend_lower_ff;
   assign row_pdiag = first_ff ? '0 : pend_diag_ff;
   assign diag_sum  = $signed({row_pdiag[FIELD_W-1], row_pdiag})
                    + $signed({diag_share[FIELD_W-1], diag_share});
   assign diag_sat  = (diag_sum[FIELD_W] != diag_sum[FIELD_W-1])
                    ? (diag_sum[FIELD_W] ? SAT_MIN : SAT_MAX)
                    : diag_sum[FIELD_W-1:0];

   // shared multiplier, operands steered by the sequencer
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         ST_PREP: begin
            mul_a = abs_vel;
            mul_b = icw_ff;
         end
         ST_MUL_LO: begin
            mul_a = m_ff[FIELD_W-1:0];
            mul_b = FIELD_W'(phi_ff);
         end
         ST_MUL_HI: begin
            mul_a = FIELD_W'(m_ff[MW-1:FIELD_W]);
            mul_b = FIELD_W'(phi_ff);
         end
         default: begin
         end
      endcase
      prod_in = (2 * FIELD_W)'(mul_a) * (2 * FIELD_W)'(mul_b);
   end

   // sequencer: next state and datapath loads
   always_comb begin
      state_in      = state_ff;
      icw_in        = icw_ff;
      pend_lower_in = pend_lower_ff;
      pend_diag_in  = pend_diag_ff;
      num_in        = num_ff;
      den_in        = den_ff;
      vel_in        = vel_ff;
      first_in      = first_ff;
      last_in       = last_ff;
      rem_in        = rem_ff;
      dvs_in        = dvs_ff;
      quo_in        = quo_ff;
      big_in        = big_ff;
      cnt_in        = cnt_ff;
      phi_in        = phi_ff;
      acc_in        = acc_ff;
      m_in          = m_ff;
      p_in          = p_ff;
      out_lower_in  = out_lower_ff;
      out_diag_in   = out_diag_ff;
      out_upper_in  = out_upper_ff;
      out_last_in   = out_last_ff;

      if (csr_write && (csr_paddr[2] == CSR_IDX_INV_CELL_WIDTH)) begin
         icw_in = csr_pwdata;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               num_in   = {st_cr[FIELD_W-1], st_cr} - {st_dn[FIELD_W-1], st_dn};
               den_in   = {st_up[FIELD_W-1], st_up} - {st_cr[FIELD_W-1], st_cr};
               vel_in   = f_vel;
               first_in = req_tuser[0];
               last_in  = req_tlast;
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            // quotient saturates when |num| >= 4|den|; else F+2 bits cover it
            rem_in   = RW'(abs_num);
            dvs_in   = {abs_den, 2'b00};
            big_in   = ({2'b00, abs_num} >= {abs_den, 2'b00});
            quo_in   = '0;
            cnt_in   = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (cnt_ff == '0) begin
               m_in = prod_ff[2*FIELD_W-1:FRAC_BITS];
            end
            if (!trial[RW]) begin
               rem_in = trial[RW-1:0];
               quo_in = {quo_ff[QW-2:0], 1'b1};
            end else begin
               rem_in = two_rem[RW-1:0];
               quo_in = {quo_ff[QW-2:0], 1'b0};
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CW'(QW - 1)) begin
               state_in = ST_PHI;
            end
         end
         ST_PHI: begin
            // superbee limiter
            if (den_zero) begin
               phi_in = num_ff[FIELD_W] ? '0 : (num_zero ? PHI_ONE : PHI_TWO);
            end else if (num_zero || (num_ff[FIELD_W] != den_ff[FIELD_W])) begin
               phi_in = '0;
            end else if (big_ff) begin
               phi_in = PHI_TWO;
            end else if (quo_ff <= PHI_HALF) begin
               phi_in = {quo_ff[QW-2:0], 1'b0};
            end else if (quo_ff <= PHI_ONE) begin
               phi_in = PHI_ONE;
            end else if (quo_ff <= PHI_TWO) begin
               phi_in = quo_ff;
            end else begin
               phi_in = PHI_TWO;
            end
            state_in = ST_MUL_LO;
         end
         ST_MUL_LO: begin
            state_in = ST_MUL_HI;
         end
         ST_MUL_HI: begin
            acc_in   = prod_ff;
            state_in = ST_SUM;
         end
         ST_SUM: begin
            p_in     = MW'(prod_sum >> (FRAC_BITS + 1));
            state_in = ST_ROW;
         end
         ST_ROW: begin
            out_lower_in  = row_lower;
            out_diag_in   = diag_sat;
            out_upper_in  = upper_share;
            out_last_in   = 1'b0;
            pend_lower_in = next_lower;
            pend_diag_in  = next_diag;
            state_in      = ST_SEND_ROW;
         end
         ST_SEND_ROW: begin
            if (rsp_fire) begin
               if (last_ff) begin
                  // final row of the grid, then the pending shares start over
                  out_lower_in  = pend_lower_ff;
                  out_diag_in   = pend_diag_ff;
                  out_upper_in  = '0;
                  out_last_in   = 1'b1;
                  pend_lower_in = '0;
                  pend_diag_in  = '0;
                  state_in      = ST_SEND_FINAL;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_SEND_FINAL: begin
            if (rsp_fire) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // configuration and pending row shares
   always_ff @(posedge clock) begin
      if (reset) begin
         icw_ff        <= FIELD_W'(1) << FRAC_BITS;
         pend_lower_ff <= '0;
         pend_diag_ff  <= '0;
      end else begin
         icw_ff        <= icw_in;
         pend_lower_ff <= pend_lower_in;
         pend_diag_ff  <= pend_diag_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      num_ff       <= num_in;
      den_ff       <= den_in;
      vel_ff       <= vel_in;
      first_ff     <= first_in;
      last_ff      <= last_in;
      rem_ff       <= rem_in;
      dvs_ff       <= dvs_in;
      quo_ff       <= quo_in;
      big_ff       <= big_in;
      cnt_ff       <= cnt_in;
      phi_ff       <= phi_in;
      prod_ff      <= prod_in;
      acc_ff       <= acc_in;
      m_ff         <= m_in;
      p_ff         <= p_in;
      out_lower_ff <= out_lower_in;
      out_diag_ff  <= out_diag_in;
      out_upper_ff <= out_upper_in;
      out_last_ff  <= out_last_in;
   end

`ifndef SYNTHESIS
   // never accepting while a row beat is offered
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("request accepted while a row is pending");

   // an accepted edge goes straight to operand preparation
   a_accept_prep: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff == ST_PREP))
      else $error("accepted edge did not start the sequencer");

   // limiter output never exceeds two
   a_phi_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MUL_LO) |-> (phi_ff <= PHI_TWO))
      else $error("phi above two");

   // limited flux never exceeds the scaled velocity
   a_p_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROW) |-> (p_ff <= m_ff))
      else $error("p larger than |v|");

   // the final-row flag only appears for a last edge
   a_last_row: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast) |-> (last_ff && (state_ff == ST_SEND_FINAL)))
      else $error("final row without a last edge");
`endif

endmodule
